// ===== rtl/core/mlp_sigmoid_inference_macros.svh =====
// Assertion macros shared by the MLP inference RTL.
// Needs clk and rst_n in the scope of use.
`ifndef MLP_SIGMOID_INFERENCE_MACROS_SVH
`define MLP_SIGMOID_INFERENCE_MACROS_SVH

// cons must hold in the same cycle as ante
`define MLP_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define MLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mlp_pkg.sv =====
// Shared types, constants and the sigmoid table for the MLP inference block.
// No dependencies.
`default_nettype none

package mlp_pkg;

    localparam int MLP_MAX_LAYERS = 4;
    localparam int MLP_MAX_WIDTH  = 16;
    localparam int DATA_BITS      = 16;
    localparam int FRAC_BITS      = 12;
    localparam int CFG_LAYERS     = 4;
    localparam int MAX_RESULTS    = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int ADDR_W         = 11;
    localparam int SIG_W          = 13;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 5;

    localparam logic FUNC_WEIGHT  = 1'b0;
    localparam logic FUNC_FEATURE = 1'b1;

    localparam logic [1:0] OP_WEIGHT   = 2'd0;
    localparam logic [1:0] OP_FEAT     = 2'd1;
    localparam logic [1:0] OP_FEAT_RUN = 2'd2;
    localparam logic [1:0] OP_RUN      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LAYER1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LAYER2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LAYER3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LAYER4 = 3'd5;

    typedef struct packed {
        logic                        func;
        logic [ADDR_W-1:0]           word_addr;
        logic signed [DATA_BITS-1:0] value;
        logic                        last;
    } in_t;

    typedef struct packed {
        logic [SIG_W-1:0] out_value;
        logic [3:0]       out_index;
        logic             out_last;
    } out_t;

    typedef struct packed {
        logic [1:0]                  op;
        logic [ADDR_W-1:0]           addr;
        logic signed [DATA_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]                             layer_count;
        logic [CFG_DATA_W-1:0]                  input_width;
        logic [CFG_LAYERS-1:0][CFG_DATA_W-1:0]  layer_width;
    } cfg_t;

    typedef logic [SIG_W-1:0] sig_tab_t [256];

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // (a*b) >> 63 on Q63 operands
    function automatic logic [63:0] q63_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    // T[i] = round(4096/(1+exp(-(i-127.5)/16)))
    function automatic sig_tab_t build_sig_table();
        sig_tab_t    tab;
        logic [63:0] one;
        logic [63:0] term;
        logic [63:0] c;
        logic [63:0] g;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] q;
        one  = 64'h8000_0000_0000_0000;
        term = one;
        c    = one;
        for (int n = 1; n <= 15; n++)
        begin
            term = udiv64(term, 64'(32 * n));
            if ((n % 2) == 1)
                c = c - term;
            else
                c = c + term;
        end
        g = q63_mul(c, c);
        e = c;
        for (int k = 0; k < 128; k++)
        begin
            d = (one + e) >> 12;
            q = udiv64(one + (d >> 1), d);
            tab[128 + k] = q[SIG_W-1:0];
            tab[127 - k] = 13'd4096 - q[SIG_W-1:0];
            e = q63_mul(e, g);
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

// ===== rtl/core/mlp_sigmoid_inference.sv =====
// Top level of the sigmoid MLP inference block: configuration registers,
// front end, command queue, back end and result queue.
// Depends on mlp_pkg, mlp_queue, mlp_front and mlp_back.
//
// Usage:
//  - Input channel (push/full): each beat is either a weight/bias word
//    (func 0, stored at word_addr) or one sample feature (func 1). A
//    feature beat with last set starts evaluation of all layers in use.
//  - Result channel (empty/pop): one beat per final-layer neuron, in
//    neuron order, out_last on the final one (at most 16 per sample).
//  - Configuration: cfg_we writes register cfg_index; the user must write
//    only while the block is idle, which the block does not enforce.
//  - Flow: weight and feature beats retire one per cycle, while the back
//    end is idle, through a two-entry command queue. After last, each
//    neuron runs on the single MAC unit in the steps issue, drain,
//    saturate and write; a final-layer neuron's result beat is pushed to
//    the result queue in its write step.
//  - Reset clears control state and registers to one layer and widths of
//    16; the weight and activation stores hold nothing until written.
//  - If the receiver stalls, the two-entry result queue fills and the back
//    end holds on the pending neuron; the front queues beats until the
//    two-entry command queue is full, then raises full.
`default_nettype none

module mlp_sigmoid_inference
    import mlp_pkg::*;
#(
    parameter int MAX_LAYERS = MLP_MAX_LAYERS,
    parameter int MAX_WIDTH  = MLP_MAX_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_t                   sample,
    output logic                       empty,
    input  wire logic                  pop,
    output out_t                       result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [2:0]                            layer_count_reg;
    logic [CFG_DATA_W-1:0]                 input_width_reg;
    logic [CFG_LAYERS-1:0][CFG_DATA_W-1:0] layer_width_reg;
    cfg_t                                  cfg;

    cmd_t                cmd_in;
    logic                cmd_push;
    logic                cmd_full;
    logic [$bits(cmd_t)-1:0] cmd_q_out;
    cmd_t                cmd_out;
    logic                cmd_empty;
    logic                cmd_pop;

    out_t                res;
    logic                res_push;
    logic                res_full;
    logic [$bits(out_t)-1:0] res_q_out;

    // register file; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= 3'd1;
            input_width_reg <= CFG_DATA_W'(16);
            for (int i = 0; i < CFG_LAYERS; i++)
                layer_width_reg[i] <= CFG_DATA_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LAYER_COUNT:  layer_count_reg    <= cfg_data[2:0];
                REG_INPUT_WIDTH:  input_width_reg    <= cfg_data;
                REG_WIDTH_LAYER1: layer_width_reg[0] <= cfg_data;
                REG_WIDTH_LAYER2: layer_width_reg[1] <= cfg_data;
                REG_WIDTH_LAYER3: layer_width_reg[2] <= cfg_data;
                REG_WIDTH_LAYER4: layer_width_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg.layer_count = layer_count_reg;
    assign cfg.input_width = input_width_reg;
    assign cfg.layer_width = layer_width_reg;

    // front end: classifies beats and tracks the feature slot
    mlp_front #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    // decouples the front from a busy back end
    mlp_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .rd    (cmd_pop),
        .rdata (cmd_q_out),
        .empty (cmd_empty)
    );

    assign cmd_out = cmd_q_out;

    // back end: stores and the MAC sequencer
    mlp_back #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // result queue: the head is the oldest beat waiting
    mlp_queue #(
        .WIDTH ($bits(out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res),
        .full  (res_full),
        .rd    (pop),
        .rdata (res_q_out),
        .empty (empty)
    );

    assign result = res_q_out;

endmodule

`default_nettype wire

// ===== rtl/core/mlp_queue.sv =====
// Small register FIFO used between front and back and on the result side.
// No package dependencies.
`default_nettype none

module mlp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign rdata = slot_reg[rptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            if (do_rd)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mlp_front.sv =====
// Front end: takes input beats, sorts them into weight writes, feature
// writes and run commands. Depends on mlp_pkg.
`default_nettype none

module mlp_front
    import mlp_pkg::*;
#(
    parameter int MAX_LAYERS = MLP_MAX_LAYERS,
    parameter int MAX_WIDTH  = MLP_MAX_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire in_t  sample,
    output logic      cmd_push,
    output cmd_t      cmd,
    input  wire logic cmd_full
);

    localparam int WS_DEPTH = MAX_LAYERS * MAX_WIDTH * (MAX_WIDTH + 1);
    localparam int CNT_W    = $clog2(MAX_WIDTH + 1);

    logic [CNT_W-1:0] fcount_reg;
    logic             accept;
    logic             feat_in;
    logic             cmd_valid;

    assign accept  = push && !cmd_full;
    assign full    = cmd_full;
    assign feat_in = (fcount_reg < CNT_W'(MAX_WIDTH));

    always_comb
    begin
        cmd.op    = OP_WEIGHT;
        cmd.addr  = sample.word_addr;
        cmd.value = sample.value;
        cmd_valid = 1'b0;
        if (sample.func == FUNC_WEIGHT)
        begin
            // writes past the store are dropped here
            cmd_valid = (int'(sample.word_addr) < WS_DEPTH);
        end
        else
        begin
            cmd.addr = ADDR_W'(fcount_reg);
            if (feat_in)
            begin
                cmd.op    = sample.last ? OP_FEAT_RUN : OP_FEAT;
                cmd_valid = 1'b1;
            end
            else if (sample.last)
            begin
                cmd.op    = OP_RUN;
                cmd_valid = 1'b1;
            end
        end
    end

    assign cmd_push = accept && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fcount_reg <= '0;
        else if (accept && sample.func == FUNC_FEATURE)
        begin
            if (sample.last)
                fcount_reg <= '0;
            else if (feat_in)
                fcount_reg <= fcount_reg + CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mlp_back.sv =====
// Back end: weight and activation stores, one MAC pipeline, bias add,
// saturation and sigmoid lookup. Depends on mlp_pkg and the macro header.
`default_nettype none

`include "mlp_sigmoid_inference_macros.svh"

module mlp_back
    import mlp_pkg::*;
#(
    parameter int MAX_LAYERS = MLP_MAX_LAYERS,
    parameter int MAX_WIDTH  = MLP_MAX_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire cmd_t cmd,
    input  wire logic cmd_empty,
    output logic      cmd_pop,
    output out_t      res,
    output logic      res_push,
    input  wire logic res_full
);

    localparam int NSTRIDE  = MAX_WIDTH + 1;
    localparam int LSTRIDE  = MAX_WIDTH * NSTRIDE;
    localparam int WS_DEPTH = MAX_LAYERS * LSTRIDE;
    localparam int WA_W     = $clog2(WS_DEPTH);
    localparam int FI_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int AS_DEPTH = 2 * MAX_WIDTH;
    localparam int LMAX     = (MAX_LAYERS < CFG_LAYERS) ? MAX_LAYERS : CFG_LAYERS;
    localparam int LI_W     = $clog2(CFG_LAYERS);
    localparam int PW       = 2 * DATA_BITS;
    localparam int ACC_W    = PW + $clog2(MAX_WIDTH) + 1;
    localparam int ZW       = ACC_W - FRAC_BITS;
    localparam int RC_W     = $clog2(MAX_RESULTS + 1);
    localparam logic signed [ZW:0] ZMAX = (ZW + 1)'(2 ** (DATA_BITS - 1) - 1);
    localparam logic signed [ZW:0] ZMIN = -((ZW + 1)'(2 ** (DATA_BITS - 1)));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_SAT   = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic signed [DATA_BITS-1:0] wmem [WS_DEPTH];
    logic signed [DATA_BITS-1:0] amem [AS_DEPTH];

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [LI_W-1:0]             layer_reg;
    logic [CNT_W-1:0]            neuron_reg;
    logic [CNT_W-1:0]            f_reg;
    logic [CNT_W-1:0]            nf_reg;
    logic                        src_reg;
    logic [WA_W-1:0]             lbase_reg;
    logic [WA_W-1:0]             nbase_reg;
    logic [RC_W-1:0]             count_reg;
    logic                        s1_v_reg;
    logic                        s1_bias_reg;
    logic                        s2_v_reg;
    logic signed [DATA_BITS-1:0] w_rd_reg;
    logic signed [DATA_BITS-1:0] a_rd_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [DATA_BITS-1:0] bias_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [7:0]                  idx_reg;

    logic [2:0]                  layers_c;
    logic [CNT_W-1:0]            nf_in;
    logic [CNT_W-1:0]            nn;
    logic                        is_final;
    logic                        f_is_bias;
    logic [WA_W-1:0]             w_raddr;
    logic [FI_W:0]               a_raddr;
    logic                        w_we;
    logic                        feat_we;
    logic                        start;
    logic                        emit;
    logic                        write_go;
    logic                        a_we;
    logic [FI_W:0]               a_waddr;
    logic signed [DATA_BITS-1:0] a_wdata;
    logic [SIG_W-1:0]            sig;
    logic signed [ZW:0]          zsum;
    logic signed [DATA_BITS-1:0] zsat;
    logic                        neuron_more;

    // register values are clamped on use
    always_comb
    begin
        if (cfg.layer_count == '0)
            layers_c = 3'd1;
        else if (int'(cfg.layer_count) > LMAX)
            layers_c = 3'(LMAX);
        else
            layers_c = cfg.layer_count;

        if (cfg.input_width == '0)
            nf_in = CNT_W'(1);
        else if (int'(cfg.input_width) > MAX_WIDTH)
            nf_in = CNT_W'(MAX_WIDTH);
        else
            nf_in = CNT_W'(cfg.input_width);

        if (cfg.layer_width[layer_reg] == '0)
            nn = CNT_W'(1);
        else if (int'(cfg.layer_width[layer_reg]) > MAX_WIDTH)
            nn = CNT_W'(MAX_WIDTH);
        else
            nn = CNT_W'(cfg.layer_width[layer_reg]);
    end

    assign is_final    = ((3'(layer_reg) + 3'd1) == layers_c);
    assign neuron_more = ((neuron_reg + CNT_W'(1)) < nn);
    assign f_is_bias   = (f_reg == nf_reg);
    assign w_raddr     = nbase_reg + (f_is_bias ? WA_W'(MAX_WIDTH) : WA_W'(f_reg));
    assign a_raddr     = {src_reg, f_reg[FI_W-1:0]};

    assign cmd_pop  = (state_reg == S_IDLE) && !cmd_empty;
    assign w_we     = cmd_pop && (cmd.op == OP_WEIGHT);
    assign feat_we  = cmd_pop && ((cmd.op == OP_FEAT) || (cmd.op == OP_FEAT_RUN));
    assign start    = cmd_pop && ((cmd.op == OP_FEAT_RUN) || (cmd.op == OP_RUN));

    assign sig      = SIG_TABLE[idx_reg];
    assign emit     = is_final && (count_reg < RC_W'(MAX_RESULTS));
    assign write_go = (state_reg == S_WRITE) && !(emit && res_full);
    assign res_push = write_go && emit;

    assign res.out_value = sig;
    assign res.out_index = 4'(neuron_reg);
    assign res.out_last  = ((neuron_reg + CNT_W'(1)) == nn) ||
                           ((count_reg + RC_W'(1)) == RC_W'(MAX_RESULTS));

    assign a_we    = feat_we || write_go;
    assign a_waddr = write_go ? {~src_reg, neuron_reg[FI_W-1:0]}
                              : {1'b0, cmd.addr[FI_W-1:0]};
    assign a_wdata = write_go ? DATA_BITS'(sig) : cmd.value;

    // bias add on the floored sum, then saturate to data width
    always_comb
    begin
        zsum = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:FRAC_BITS]} +
               {{(ZW + 1 - DATA_BITS){bias_reg[DATA_BITS-1]}}, bias_reg};
        if (zsum > ZMAX)
            zsat = DATA_BITS'(ZMAX);
        else if (zsum < ZMIN)
            zsat = DATA_BITS'(ZMIN);
        else
            zsat = DATA_BITS'(zsum);
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[WA_W'(cmd.addr)] <= cmd.value;
        w_rd_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            amem[a_waddr] <= a_wdata;
        a_rd_reg <= amem[a_raddr];
    end

    // MAC datapath
    always_ff @(posedge clk)
    begin
        if (s1_v_reg && s1_bias_reg)
            bias_reg <= w_rd_reg;
        if (s1_v_reg && !s1_bias_reg)
            prod_reg <= w_rd_reg * a_rd_reg;
        if (state_reg == S_SAT)
            idx_reg <= {~zsat[DATA_BITS-1], zsat[DATA_BITS-2:DATA_BITS-8]};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_ISSUE;
            S_ISSUE: if (f_is_bias) state_next = S_DRAIN;
            S_DRAIN: if (!s1_v_reg && !s2_v_reg) state_next = S_SAT;
            S_SAT:   state_next = S_WRITE;
            S_WRITE:
            begin
                if (write_go)
                    state_next = (neuron_more || !is_final) ? S_ISSUE : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            layer_reg   <= '0;
            neuron_reg  <= '0;
            f_reg       <= '0;
            nf_reg      <= CNT_W'(1);
            src_reg     <= 1'b0;
            lbase_reg   <= '0;
            nbase_reg   <= '0;
            count_reg   <= '0;
            s1_v_reg    <= 1'b0;
            s1_bias_reg <= 1'b0;
            s2_v_reg    <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            s1_v_reg    <= (state_reg == S_ISSUE);
            s1_bias_reg <= f_is_bias;
            s2_v_reg    <= s1_v_reg && !s1_bias_reg;
            if (s2_v_reg)
                acc_reg <= acc_reg + {{(ACC_W - PW){prod_reg[PW-1]}}, prod_reg};

            if (start)
            begin
                layer_reg  <= '0;
                neuron_reg <= '0;
                f_reg      <= '0;
                nf_reg     <= nf_in;
                src_reg    <= 1'b0;
                lbase_reg  <= '0;
                nbase_reg  <= '0;
                count_reg  <= '0;
                acc_reg    <= '0;
            end

            if (state_reg == S_ISSUE)
                f_reg <= f_reg + CNT_W'(1);

            if (write_go)
            begin
                if (emit)
                    count_reg <= count_reg + RC_W'(1);
                f_reg   <= '0;
                acc_reg <= '0;
                if (neuron_more)
                begin
                    neuron_reg <= neuron_reg + CNT_W'(1);
                    nbase_reg  <= nbase_reg + WA_W'(NSTRIDE);
                end
                else if (!is_final)
                begin
                    layer_reg  <= layer_reg + LI_W'(1);
                    neuron_reg <= '0;
                    lbase_reg  <= lbase_reg + WA_W'(LSTRIDE);
                    nbase_reg  <= lbase_reg + WA_W'(LSTRIDE);
                    nf_reg     <= nn;
                    src_reg    <= ~src_reg;
                end
            end
        end
    end

    `MLP_ASSERT_HOLDS(a_sat_drained, state_reg == S_SAT, !s1_v_reg && !s2_v_reg, "MAC pipeline not drained at saturation")
    `MLP_ASSERT_HOLDS(a_issue_range, state_reg == S_ISSUE, f_reg <= nf_reg, "feature counter ran past fan-in")
    `MLP_ASSERT_HOLDS(a_count_cap, 1'b1, count_reg <= RC_W'(MAX_RESULTS), "result count over limit")
    `MLP_ASSERT_NEXT(a_next_neuron, write_go && (neuron_more || !is_final), state_reg == S_ISSUE && f_reg == '0, "next neuron did not restart issue")

endmodule

`default_nettype wire
